### src/lru_replacement_tracker_core_macros.svh
// lru_replacement_tracker_core_macros.svh: assertion macros for the lru tracker checker
// depends on: nothing; expects clk_i and rst_ni in the including scope
`ifndef LRU_REPLACEMENT_TRACKER_CORE_MACROS_SVH
`define LRU_REPLACEMENT_TRACKER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lrt check failed");

// antecedent implies consequent in the following cycle
`define LRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrt check failed");

`endif

### src/lrt_pkg.sv
// lrt_pkg: opcodes and default sizes for the lru replacement tracker
// depends on: nothing
`timescale 1ns / 1ps

package lrt_pkg;

  localparam int CapacityDef = 64;
  localparam int KeyBitsDef  = 10;
  localparam int OpBits      = 2;

  typedef enum logic [OpBits-1:0] {
    OP_INSERT = 2'd0,
    OP_EVICT  = 2'd1,
    OP_ERASE  = 2'd2
  } opcode_e;

endpackage

### src/lru_replacement_tracker_core.sv
// lru_replacement_tracker_core: lru order of up to CAPACITY keys, insert/evict/erase
// depends on: lrt_pkg
//
//   channel   handshake        fields
//   command   start_i, busy_o  opcode_i, key_i
//   result    done_o strobe    ok_o, victim_key_o, occupancy_o, full_error_o
//
// one command beat per cycle while busy_o is low; each command passes through the input register,
// one compare-and-shift pass over the key cells and the result register before done_o shows it.
// the next command sees the state the previous one left.
// busy_o is high during reset and for the first cycle after it; the result side cannot stall.
`timescale 1ns / 1ps

module lru_replacement_tracker_core #(
  parameter int CAPACITY = lrt_pkg::CapacityDef,
  parameter int KEY_BITS = lrt_pkg::KeyBitsDef,
  localparam int CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [lrt_pkg::OpBits-1:0]  opcode_i,
  input  logic [KEY_BITS-1:0]         key_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [KEY_BITS-1:0]         victim_key_o,
  output logic [CntW-1:0]             occupancy_o,
  output logic                        full_error_o
);

  logic                 busy_q;
  logic                 in_valid_q;
  lrt_pkg::opcode_e     op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [KEY_BITS-1:0]  cell_q [CAPACITY];
  logic [KEY_BITS-1:0]  cell_d [CAPACITY];
  logic [KEY_BITS-1:0]  nbr    [CAPACITY];

  logic                 done_q;
  logic                 ok_q, ok_d;
  logic [KEY_BITS-1:0]  victim_q, victim_d;
  logic [CntW-1:0]      occ_q;
  logic                 full_q, full_d;

  logic [CAPACITY-1:0]  match;
  logic [CAPACITY-1:0]  at_or_above;
  logic [CAPACITY-1:0]  shift_sel;
  logic                 hit;
  logic                 wr_en;
  logic [CntW-1:0]      wr_pos;

  // parallel compare against valid cells
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CntW'(i) < count_q) && (cell_q[i] == key_q);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      at_or_above[i] = |(match & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      nbr[i] = cell_q[i + 1];
    end
    nbr[CAPACITY-1] = cell_q[CAPACITY-1];
    hit = |match;
  end

  always_comb begin
    shift_sel = '0;
    wr_en     = 1'b0;
    wr_pos    = count_q;
    count_d   = count_q;
    ok_d      = 1'b0;
    victim_d  = '0;
    full_d    = 1'b0;
    case (op_q)
      lrt_pkg::OP_INSERT: begin
        if (hit) begin
          shift_sel = at_or_above;
          wr_en     = 1'b1;
          wr_pos    = count_q - CntW'(1);
          ok_d      = 1'b1;
        end else if (count_q < CntW'(CAPACITY)) begin
          wr_en   = 1'b1;
          count_d = count_q + CntW'(1);
          ok_d    = 1'b1;
        end else begin
          full_d = 1'b1;
        end
      end
      lrt_pkg::OP_EVICT: begin
        if (count_q != '0) begin
          shift_sel = '1;
          victim_d  = cell_q[0];
          count_d   = count_q - CntW'(1);
          ok_d      = 1'b1;
        end
      end
      lrt_pkg::OP_ERASE: begin
        if (hit) begin
          shift_sel = at_or_above;
          count_d   = count_q - CntW'(1);
          ok_d      = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < CAPACITY; i++) begin
      if (wr_en && (wr_pos == CntW'(i))) begin
        cell_d[i] = key_q;
      end else if (shift_sel[i]) begin
        cell_d[i] = nbr[i];
      end else begin
        cell_d[i] = cell_q[i];
      end
    end
  end

  // key cells, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
      count_q    <= '0;
    end else begin
      busy_q     <= 1'b0;
      in_valid_q <= start_i && !busy_q;
      done_q     <= in_valid_q;
      if (in_valid_q) begin
        count_q <= count_d;
      end
    end
  end

  // input and result payload
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      op_q  <= lrt_pkg::opcode_e'(opcode_i);
      key_q <= key_i;
    end
    if (in_valid_q) begin
      ok_q     <= ok_d;
      victim_q <= victim_d;
      occ_q    <= count_d;
      full_q   <= full_d;
    end
  end

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign victim_key_o = victim_q;
  assign occupancy_o  = occ_q;
  assign full_error_o = full_q;

endmodule

### src/lrt_checker.sv
// lrt_checker: port-level checks for the lru tracker, bound to lru_replacement_tracker_core
// depends on: lrt_pkg, lru_replacement_tracker_core_macros.svh, lru_replacement_tracker_core
`timescale 1ns / 1ps
`include "lru_replacement_tracker_core_macros.svh"

module lrt_checker #(
  parameter int CAPACITY = lrt_pkg::CapacityDef,
  parameter int KEY_BITS = lrt_pkg::KeyBitsDef,
  localparam int CntW    = $clog2(CAPACITY + 1)
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic [lrt_pkg::OpBits-1:0] opcode_i,
  input logic                       done_o,
  input logic                       ok_o,
  input logic [KEY_BITS-1:0]        victim_key_o,
  input logic [CntW-1:0]            occupancy_o,
  input logic                       full_error_o
);

  logic accept;
  logic evict_beat;

  assign accept     = start_i && !busy_o;
  assign evict_beat = accept && (opcode_i == lrt_pkg::OP_EVICT);

  // each beat yields exactly one result, through the input register and the result register
  `LRT_ASSERT_NOW(a_one_result, 1'b1, done_o == $past(accept, 2))
  // a rejected insert only happens when full
  `LRT_ASSERT_NOW(a_full_reject, done_o && full_error_o,
                  !ok_o && (occupancy_o == CntW'(CAPACITY)))
  // occupancy stays within capacity
  `LRT_ASSERT_NOW(a_occ_bound, done_o, occupancy_o <= CntW'(CAPACITY))
  // victim key only comes from a successful evict
  `LRT_ASSERT_NEXT(a_victim_src, !evict_beat, ##1 (!done_o || victim_key_o == '0))

endmodule

bind lru_replacement_tracker_core lrt_checker #(
  .CAPACITY(CAPACITY),
  .KEY_BITS(KEY_BITS)
) u_lrt_checker (.*);
